// ===== rtl/core/tlts_pkg.sv =====
// Shared types and constants for the two-level thread scheduler core.
// Holds the request and result payload structs, operation and status codes.
// No dependencies.
package tlts_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int NUM_SEMS    = 4;
	localparam int NUM_REGS    = 4;
	localparam int NUM_LEVELS  = 2;
	localparam int PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;

	localparam logic [7:0] COUNT_MAX = 8'd255;

	typedef enum logic [2:0] {
		OP_CREATE    = 3'd0,
		OP_YIELD     = 3'd1,
		OP_TERMINATE = 3'd2,
		OP_SEM_WAIT  = 3'd3,
		OP_SEM_SIG   = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_FULL     = 2'd1,
		ST_NO_READY = 2'd2,
		ST_SHUTDOWN = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] new_tid;
		logic       new_level;
		logic [1:0] sem_id;
	} req_t;

	typedef struct packed {
		logic       running_valid;
		logic [7:0] running_id;
		logic       running_level;
		logic       switched;
		logic [1:0] status;
	} res_t;

endpackage

// ===== rtl/core/two_level_thread_scheduler_core.sv =====
// Flow: an accepted request waits in the request register until the result register
// can take its result. Throughput: one request per cycle while res_stall does not
// hold a result; the work between the two touches only queue heads, tails and counters.
// Reset: thread 0 runs at priority 1, all ready and wait queues are empty and
// every semaphore count and start register reads zero. No clearing pass is needed.
// Top level of the scheduler; depends on tlts_pkg.
module two_level_thread_scheduler_core import tlts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req_data,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// Request stage and result register
	logic       valid_s1;
	req_t       req_s1;
	logic       res_valid_q;
	res_t       res_q;
	logic       adv;
	logic       fire;
	logic       accept;

	// Running thread
	logic       run_valid_q;
	logic [7:0] run_id_q;
	logic       run_pri_q;

	// Ready queues, one per priority level
	logic [PTR_W-1:0] rdy_head_q [NUM_LEVELS];
	logic [PTR_W-1:0] rdy_tail_q [NUM_LEVELS];
	logic [CNT_W-1:0] rdy_cnt_q  [NUM_LEVELS];
	logic [7:0]       rdy_front  [NUM_LEVELS];
	logic [NUM_LEVELS-1:0] rdy_push;
	logic [NUM_LEVELS-1:0] rdy_pop;
	logic [7:0]       rdy_push_id;

	// Semaphores and their wait queues
	logic [7:0]       sem_start_q [NUM_REGS];
	logic [7:0]       sem_cnt_q   [NUM_SEMS];
	logic [PTR_W-1:0] wait_head_q [NUM_SEMS];
	logic [PTR_W-1:0] wait_tail_q [NUM_SEMS];
	logic [CNT_W-1:0] wait_cnt_q  [NUM_SEMS];
	logic [8:0]       wait_front  [NUM_SEMS];
	logic             wait_push;
	logic             wait_pop;
	logic [8:0]       wait_push_data;
	logic             sem_dec;
	logic             sem_inc;

	// Configuration port
	logic             cfg_wr;
	logic [1:0]       cfg_idx;

	// Next-state and result terms
	logic       run_valid_n;
	logic [7:0] run_id_n;
	logic       run_pri_n;
	logic       sw;
	status_t    st;
	logic       disp_avail;
	logic       disp_lvl;
	logic [7:0] disp_id;
	logic       sem_ok;
	logic [1:0] sid;
	logic       wlvl;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];
	assign prdata  = {{(DATA_W - 8){1'b0}}, sem_start_q[cfg_idx]};

	assign adv       = !res_valid_q || !res_stall;
	assign fire      = valid_s1 && adv;
	assign req_stall = valid_s1 && !adv;
	assign accept    = req_valid && !req_stall;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				res_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1 <= req_data;
		end
		if (fire) begin
			res_q.running_valid <= run_valid_n;
			res_q.running_id    <= run_valid_n ? run_id_n : 8'd0;
			res_q.running_level <= run_valid_n ? run_pri_n : 1'b0;
			res_q.switched      <= sw;
			res_q.status        <= st;
		end
	end

	// Ready queue storage and pointers
	for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_rdy
		logic [7:0] mem_q [QUEUE_DEPTH];
		logic       wr;
		logic       rd;

		assign wr           = fire && rdy_push[l];
		assign rd           = fire && rdy_pop[l];
		assign rdy_front[l] = mem_q[rdy_head_q[l]];

		always_ff @(posedge clk) begin
			if (wr) begin
				mem_q[rdy_tail_q[l]] <= rdy_push_id;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rdy_head_q[l] <= '0;
				rdy_tail_q[l] <= '0;
				rdy_cnt_q[l]  <= '0;
			end else begin
				if (wr) begin
					rdy_tail_q[l] <= ptr_inc(rdy_tail_q[l]);
				end
				if (rd) begin
					rdy_head_q[l] <= ptr_inc(rdy_head_q[l]);
				end
				if (wr && !rd) begin
					rdy_cnt_q[l] <= rdy_cnt_q[l] + 1'b1;
				end else if (rd && !wr) begin
					rdy_cnt_q[l] <= rdy_cnt_q[l] - 1'b1;
				end
			end
		end
	end

	// Wait queue storage and pointers, one queue per semaphore
	for (genvar i = 0; i < NUM_SEMS; i++) begin : g_wait
		logic [8:0] mem_q [QUEUE_DEPTH];
		logic       wr;
		logic       rd;
		logic       clr;

		assign wr            = fire && wait_push && (sid == 2'(i));
		assign rd            = fire && wait_pop && (sid == 2'(i));
		assign clr           = cfg_wr && (cfg_idx == 2'(i));
		assign wait_front[i] = mem_q[wait_head_q[i]];

		always_ff @(posedge clk) begin
			if (wr) begin
				mem_q[wait_tail_q[i]] <= wait_push_data;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				wait_head_q[i] <= '0;
				wait_tail_q[i] <= '0;
				wait_cnt_q[i]  <= '0;
				sem_cnt_q[i]   <= '0;
			end else if (clr) begin
				wait_head_q[i] <= '0;
				wait_tail_q[i] <= '0;
				wait_cnt_q[i]  <= '0;
				sem_cnt_q[i]   <= pwdata[7:0];
			end else begin
				if (wr) begin
					wait_tail_q[i] <= ptr_inc(wait_tail_q[i]);
					wait_cnt_q[i]  <= wait_cnt_q[i] + 1'b1;
				end
				if (rd) begin
					wait_head_q[i] <= ptr_inc(wait_head_q[i]);
					wait_cnt_q[i]  <= wait_cnt_q[i] - 1'b1;
				end
				if (fire && sem_dec && (sid == 2'(i))) begin
					sem_cnt_q[i] <= sem_cnt_q[i] - 1'b1;
				end
				if (fire && sem_inc && (sid == 2'(i))) begin
					sem_cnt_q[i] <= sem_cnt_q[i] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < NUM_REGS; r++) begin
				sem_start_q[r] <= '0;
			end
		end else if (cfg_wr) begin
			sem_start_q[cfg_idx] <= pwdata[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b1;
			run_id_q    <= 8'd0;
			run_pri_q   <= 1'b1;
		end else if (fire) begin
			run_valid_q <= run_valid_n;
			run_id_q    <= run_id_n;
			run_pri_q   <= run_pri_n;
		end
	end

	// The first non-empty ready queue, level 0 before level 1, supplies the next thread.
	assign disp_avail = (rdy_cnt_q[0] != '0) || (rdy_cnt_q[1] != '0);
	assign disp_lvl   = (rdy_cnt_q[0] == '0);
	assign disp_id    = disp_lvl ? rdy_front[1] : rdy_front[0];
	assign sid        = req_s1.sem_id;
	assign sem_ok     = 32'(sid) < NUM_SEMS;
	assign wlvl       = wait_front[sid][8];

	always_comb begin
		run_valid_n    = run_valid_q;
		run_id_n       = run_id_q;
		run_pri_n      = run_pri_q;
		sw             = 1'b0;
		st             = ST_OK;
		rdy_push       = '0;
		rdy_pop        = '0;
		rdy_push_id    = req_s1.new_tid;
		wait_push      = 1'b0;
		wait_pop       = 1'b0;
		wait_push_data = {run_pri_q, run_id_q};
		sem_dec        = 1'b0;
		sem_inc        = 1'b0;
		case (req_s1.op)
			OP_CREATE: begin
				if (rdy_cnt_q[req_s1.new_level] == CNT_W'(QUEUE_DEPTH)) begin
					st = ST_FULL;
				end else begin
					rdy_push[req_s1.new_level] = 1'b1;
				end
			end
			OP_YIELD: begin
				if (!run_valid_q) begin
					if (disp_avail) begin
						rdy_pop[disp_lvl] = 1'b1;
						run_valid_n       = 1'b1;
						run_id_n          = disp_id;
						run_pri_n         = disp_lvl;
						sw                = 1'b1;
					end else begin
						st = ST_NO_READY;
					end
				end else if ((rdy_cnt_q[0] != '0) || (run_pri_q && (rdy_cnt_q[1] != '0))) begin
					rdy_pop[disp_lvl] = 1'b1;
					run_id_n          = disp_id;
					run_pri_n         = disp_lvl;
					sw                = 1'b1;
					rdy_push_id       = run_id_q;
					// A pop from the same queue frees the slot the old thread needs.
					if ((rdy_cnt_q[run_pri_q] == CNT_W'(QUEUE_DEPTH)) &&
							(disp_lvl != run_pri_q)) begin
						st = ST_FULL;
					end else begin
						rdy_push[run_pri_q] = 1'b1;
					end
				end
			end
			OP_TERMINATE: begin
				if (disp_avail) begin
					rdy_pop[disp_lvl] = 1'b1;
					run_valid_n       = 1'b1;
					run_id_n          = disp_id;
					run_pri_n         = disp_lvl;
					sw                = 1'b1;
				end else begin
					run_valid_n = 1'b0;
					st          = ST_SHUTDOWN;
					sw          = run_valid_q;
				end
			end
			OP_SEM_WAIT: begin
				if (sem_ok) begin
					if (!run_valid_q) begin
						st = ST_NO_READY;
					end else if (sem_cnt_q[sid] != 8'd0) begin
						sem_dec = 1'b1;
					end else begin
						if (wait_cnt_q[sid] == CNT_W'(QUEUE_DEPTH)) begin
							st = ST_FULL;
						end else begin
							wait_push = 1'b1;
						end
						sw = 1'b1;
						if (disp_avail) begin
							rdy_pop[disp_lvl] = 1'b1;
							run_id_n          = disp_id;
							run_pri_n         = disp_lvl;
						end else begin
							run_valid_n = 1'b0;
							if (st == ST_OK) begin
								st = ST_NO_READY;
							end
						end
					end
				end
			end
			OP_SEM_SIG: begin
				if (sem_ok) begin
					if ((wait_cnt_q[sid] == '0) || (sem_cnt_q[sid] != 8'd0)) begin
						sem_inc = (sem_cnt_q[sid] != COUNT_MAX);
					end else begin
						// Mesa hand-off: the waiter becomes ready but does not preempt.
						wait_pop    = 1'b1;
						rdy_push_id = wait_front[sid][7:0];
						if (rdy_cnt_q[wlvl] == CNT_W'(QUEUE_DEPTH)) begin
							st = ST_FULL;
						end else begin
							rdy_push[wlvl] = 1'b1;
						end
					end
				end
			end
			default: begin
				st = ST_OK;
			end
		endcase
	end

endmodule

// ===== tb/sv/tb_two_level_thread_scheduler_core.sv =====
// Self-checking testbench for two_level_thread_scheduler_core: scheduler requests,
// semaphore start registers over the APB port, results checked against a local model.
// Depends on tlts_pkg and the core RTL.
module tb_two_level_thread_scheduler_core;
	import tlts_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 5;
	localparam int IDLE_PCT     = 27;
	localparam int NUM_FIFOS    = NUM_LEVELS + NUM_SEMS;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	req_t              req_data  = '0;
	logic              res_valid;
	logic              res_stall = 1'b0;
	res_t              res_data;
	logic              psel      = 1'b0;
	logic              penable   = 1'b0;
	logic              pwrite    = 1'b0;
	logic [ADDR_W-1:0] paddr     = '0;
	logic [DATA_W-1:0] pwdata    = '0;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// Scheduler model: running thread, ready FIFOs (one per level) followed by
	// one wait FIFO per semaphore, all in one ring-buffer store.
	logic       run_on;
	logic [7:0] run_tid;
	logic       run_lvl;
	logic [7:0] sem_level [NUM_SEMS];
	logic [8:0] fifo_slot [NUM_FIFOS][QUEUE_DEPTH];
	int         fifo_head [NUM_FIFOS];
	int         fifo_fill [NUM_FIFOS];

	req_t ops_to_send [$];
	res_t reports_due [$];
	bit   req_taken = 1'b0;
	bit   steady    = 1'b0;
	int   cycles    = 0;
	int   sent      = 0;
	int   checked   = 0;
	int   mismatches = 0;
	int   switches  = 0;
	int   status_seen [4] = '{0, 0, 0, 0};

	two_level_thread_scheduler_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic bit fifo_push(int q, logic [8:0] v);
		if (fifo_fill[q] >= QUEUE_DEPTH)
			return 1'b0;
		fifo_slot[q][(fifo_head[q] + fifo_fill[q]) % QUEUE_DEPTH] = v;
		fifo_fill[q]++;
		return 1'b1;
	endfunction

	function automatic logic [8:0] fifo_pop(int q);
		logic [8:0] v;
		v = fifo_slot[q][fifo_head[q]];
		fifo_head[q] = (fifo_head[q] + 1) % QUEUE_DEPTH;
		fifo_fill[q]--;
		return v;
	endfunction

	// Starts the head of the most urgent non-empty ready FIFO.
	function automatic bit dispatch_next();
		logic [8:0] v;
		for (int l = 0; l < NUM_LEVELS; l++) begin
			if (fifo_fill[l] != 0) begin
				v = fifo_pop(l);
				run_tid = v[7:0];
				run_lvl = l[0];
				run_on = 1'b1;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic res_t schedule_op(req_t r);
		status_t    st;
		logic       moved;
		logic       was_on;
		logic [7:0] old_tid;
		logic       old_lvl;
		logic [8:0] w;
		int         wq;
		res_t       y;
		st = ST_OK;
		moved = 1'b0;
		wq = NUM_LEVELS + int'(r.sem_id);
		case (r.op)
		OP_CREATE: begin
			if (!fifo_push(int'(r.new_level), {1'b0, r.new_tid}))
				st = ST_FULL;
		end
		OP_YIELD: begin
			if (!run_on) begin
				if (dispatch_next())
					moved = 1'b1;
				else
					st = ST_NO_READY;
			end else if (fifo_fill[0] != 0 || (run_lvl && fifo_fill[1] != 0)) begin
				old_tid = run_tid;
				old_lvl = run_lvl;
				void'(dispatch_next());
				if (!fifo_push(int'(old_lvl), {1'b0, old_tid}))
					st = ST_FULL;
				moved = 1'b1;
			end
		end
		OP_TERMINATE: begin
			was_on = run_on;
			run_on = 1'b0;
			if (dispatch_next()) begin
				moved = 1'b1;
			end else begin
				st = ST_SHUTDOWN;
				moved = was_on;
			end
		end
		OP_SEM_WAIT: begin
			if (r.sem_id < NUM_SEMS) begin
				if (!run_on) begin
					st = ST_NO_READY;
				end else if (sem_level[r.sem_id] != 0) begin
					sem_level[r.sem_id]--;
				end else begin
					if (!fifo_push(wq, {run_lvl, run_tid}))
						st = ST_FULL;
					run_on = 1'b0;
					moved = 1'b1;
					if (!dispatch_next() && st == ST_OK)
						st = ST_NO_READY;
				end
			end
		end
		OP_SEM_SIG: begin
			if (r.sem_id < NUM_SEMS) begin
				if (fifo_fill[wq] == 0 || sem_level[r.sem_id] != 0) begin
					if (sem_level[r.sem_id] != COUNT_MAX)
						sem_level[r.sem_id]++;
				end else begin
					// Mesa hand-off: the waiter becomes ready but does not preempt.
					w = fifo_pop(wq);
					if (!fifo_push(int'(w[8]), {1'b0, w[7:0]}))
						st = ST_FULL;
				end
			end
		end
		default: begin
		end
		endcase
		y.running_valid = run_on;
		y.running_id = run_on ? run_tid : 8'd0;
		y.running_level = run_on ? run_lvl : 1'b0;
		y.switched = moved;
		y.status = st;
		return y;
	endfunction

	task automatic field_check(string name, logic [7:0] want, logic [7:0] got);
		if (got !== want) begin
			$error("%s expected %0d got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic check_report(res_t got);
		res_t want;
		if (reports_due.size() == 0) begin
			$error("result with no request outstanding: %p", got);
			mismatches++;
			return;
		end
		want = reports_due.pop_front();
		checked++;
		field_check("running_valid", want.running_valid, got.running_valid);
		field_check("running_id", want.running_id, got.running_id);
		field_check("running_level", want.running_level, got.running_level);
		field_check("switched", want.switched, got.switched);
		field_check("status", want.status, got.status);
		if (want.switched)
			switches++;
		status_seen[want.status]++;
	endtask

	// Request driver: a new request is offered only once the previous one has gone.
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (req_taken || !req_valid) begin
			if (ops_to_send.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
				req_data <= ops_to_send.pop_front();
				req_valid <= 1'b1;
			end else begin
				req_valid <= 1'b0;
			end
		end
		res_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
	end

	// Monitor: checks results, predicts accepted requests and guards the run time.
	always @(posedge clk) begin
		cycles++;
		if (arst_n && res_valid && !res_stall)
			check_report(res_data);
		req_taken = arst_n && req_valid && !req_stall;
		if (req_taken) begin
			reports_due.push_back(schedule_op(req_data));
			sent++;
		end
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAIL two_level_thread_scheduler_core");
			$finish;
		end
	end

	task automatic write_sem_start(int idx, logic [7:0] value);
		logic [23:0] junk;
		junk = 24'($urandom());
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(idx * 4);
		pwdata <= {junk, value};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		// A start write also empties that semaphore's wait queue.
		sem_level[idx] = value;
		fifo_head[NUM_LEVELS + idx] = 0;
		fifo_fill[NUM_LEVELS + idx] = 0;
	endtask

	task automatic write_all_starts(logic [7:0] s0, logic [7:0] s1, logic [7:0] s2,
			logic [7:0] s3);
		write_sem_start(0, s0);
		write_sem_start(1, s1);
		write_sem_start(2, s2);
		write_sem_start(3, s3);
	endtask

	task automatic add_op(int op, int tid, int pri, int sem);
		req_t r;
		r.op = 3'(op);
		r.new_tid = 8'(tid);
		r.new_level = 1'(pri);
		r.sem_id = 2'(sem);
		ops_to_send.push_back(r);
	endtask

	// Waits until every request has gone and every result has come back.
	task automatic drain();
		while (ops_to_send.size() != 0 || req_valid || reports_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Expects start values 0, 255, 1 and 0x5A.
	task automatic queue_directed();
		add_op(OP_CREATE, 8'hFF, 1'b0, 2'd3);
		add_op(OP_CREATE, 8'h00, 1'b1, 2'd0);
		add_op(OP_YIELD, 8'h00, 1'b0, 2'd0);
		add_op(OP_YIELD, 8'h00, 1'b0, 2'd0);
		add_op(OP_SEM_WAIT, 8'h00, 1'b0, 2'd0);
		add_op(OP_SEM_WAIT, 8'h00, 1'b0, 2'd1);
		add_op(OP_SEM_SIG, 8'h00, 1'b0, 2'd1);
		add_op(OP_SEM_SIG, 8'h00, 1'b0, 2'd1);
		add_op(OP_SEM_SIG, 8'h00, 1'b0, 2'd0);
		repeat (4) add_op(OP_TERMINATE, 8'h00, 1'b0, 2'd0);
		add_op(OP_YIELD, 8'h00, 1'b0, 2'd0);
		add_op(OP_SEM_WAIT, 8'h00, 1'b0, 2'd3);
		add_op(OP_CREATE, 8'hAA, 1'b0, 2'd0);
		add_op(OP_CREATE, 8'h55, 1'b1, 2'd0);
		add_op(OP_YIELD, 8'h00, 1'b0, 2'd0);
		repeat (3) add_op(OP_SEM_WAIT, 8'h00, 1'b0, 2'd2);
		repeat (2) add_op(OP_SEM_SIG, 8'h00, 1'b0, 2'd2);
		add_op(OP_YIELD, 8'h00, 1'b0, 2'd0);
		add_op(3'd5, 8'hFF, 1'b1, 2'd3);
		add_op(3'd6, 8'h00, 1'b0, 2'd0);
		add_op(3'd7, 8'hA5, 1'b1, 2'd1);
	endtask

	// Mostly bursts that fill queues, pile threads onto one semaphore or release
	// them, with some loose operations and undefined op codes mixed in.
	task automatic queue_random(int n);
		int added;
		int len;
		int kind;
		int s;
		int mode;
		added = 0;
		while (added < n) begin
			kind = $urandom_range(99);
			s = $urandom_range(NUM_SEMS - 1);
			mode = $urandom_range(2);
			if (kind < 22) begin
				len = $urandom_range(20, 1);
				repeat (len)
					add_op(OP_CREATE, $urandom, mode == 2 ? $urandom_range(1) : mode, $urandom);
			end else if (kind < 40) begin
				len = $urandom_range(6, 1);
				repeat (len) add_op(OP_YIELD, $urandom, $urandom, $urandom);
			end else if (kind < 55) begin
				len = $urandom_range(18, 1);
				repeat (len) add_op(OP_SEM_WAIT, $urandom, $urandom, s);
			end else if (kind < 70) begin
				len = $urandom_range(18, 1);
				repeat (len) add_op(OP_SEM_SIG, $urandom, $urandom, s);
			end else if (kind < 78) begin
				len = $urandom_range(4, 1);
				repeat (len) add_op(OP_TERMINATE, $urandom, $urandom, $urandom);
				add_op(OP_YIELD, $urandom, $urandom, $urandom);
				len++;
			end else if (kind < 90) begin
				len = $urandom_range(10, 1);
				repeat (len) add_op($urandom_range(4), $urandom, $urandom, $urandom);
			end else begin
				len = $urandom_range(5, 1);
				repeat (len) add_op($urandom_range(7), $urandom, $urandom, $urandom);
			end
			added += len;
		end
	endtask

	initial begin
		run_on = 1'b1;
		run_tid = 8'd0;
		run_lvl = 1'b1;
		for (int i = 0; i < NUM_SEMS; i++)
			sem_level[i] = 8'd0;
		for (int i = 0; i < NUM_FIFOS; i++) begin
			fifo_head[i] = 0;
			fifo_fill[i] = 0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		write_all_starts(8'd0, 8'd255, 8'd1, 8'h5A);
		queue_directed();
		queue_random(220);
		drain();
		write_all_starts(8'd255, 8'd0, 8'd0, 8'd255);
		queue_random(222);
		drain();
		write_all_starts(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		queue_random(222);
		drain();
		write_all_starts(8'd0, 8'd0, 8'd0, 8'd0);
		queue_random(222);
		drain();
		// A stretch with no idling on either side.
		steady = 1'b1;
		write_all_starts(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
		queue_random(222);
		drain();
		steady = 1'b0;
		write_all_starts(8'd1, 8'd2, 8'd128, 8'd254);
		queue_random(222);
		drain();

		$display("Checked %0d results for %0d requests over six semaphore settings;",
			checked, sent);
		$display("%0d switches, %0d drops on full queues, %0d idle and %0d shutdown results.",
			switches, status_seen[ST_FULL], status_seen[ST_NO_READY],
			status_seen[ST_SHUTDOWN]);
		if (mismatches == 0 && reports_due.size() == 0) begin
			$display("PASS two_level_thread_scheduler_core");
		end else begin
			$display("FAIL two_level_thread_scheduler_core");
		end
		$finish;
	end

endmodule
